>>> hw/rtl/bht_pkg.sv
// Shared types, constants and command/status bundles of the block hotness tracker.
package bht_pkg;

   // Geometry and field widths
   localparam int NUM_BLOCKS       = 4096;
   localparam int NUM_TEMPERATURES = 4;
   localparam int WEIGHT_SLOTS     = 4;
   localparam int BLK_W            = 12;
   localparam int SECTOR_W         = 48;
   localparam int END_W            = 49;
   localparam int CNT_W            = 32;
   localparam int RND_W            = 31;
   localparam int SCORE_W          = 63;
   localparam int THR_W            = 12;
   localparam int LIMIT_W          = 31;
   localparam int WEIGHT_W         = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 31;
   localparam int MODE_W           = 2;
   localparam int TEMP_W           = 2;
   localparam int ANCHOR_W         = 2;

   // Arithmetic unit widths: 33x32 product, 66-bit dividend, 34-bit divisor
   localparam int FREQ_W    = CNT_W + 1;
   localparam int PROD_W    = FREQ_W + CNT_W;
   localparam int DVD_W     = PROD_W + 1;
   localparam int DVS_W     = FREQ_W + 1;
   localparam int DIV_CNT_W = $clog2(DVD_W + 1);

   localparam int HALVE_SHIFT          = 1;
   localparam int RESET_RAND_THRESHOLD = 4;
   localparam logic [RND_W-1:0] INT_MAX = '1;

   // Reset values of the configuration registers
   localparam logic [LIMIT_W-1:0]  DEFAULT_MAX_COUNT = LIMIT_W'(65535);
   localparam logic [LIMIT_W-1:0]  DEFAULT_MAX_DECAY = LIMIT_W'(32768);
   localparam logic [WEIGHT_W-1:0] RESET_FREQ_WEIGHT = WEIGHT_W'(1);

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEGRADE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SCORE   = 2'd3;

   // Score anchors
   localparam logic [ANCHOR_W-1:0] ANCHOR_NONE      = 2'd0;
   localparam logic [ANCHOR_W-1:0] ANCHOR_FORCE_HOT = 2'd1;
   localparam logic [ANCHOR_W-1:0] ANCHOR_COLD      = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STAT_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STAT_DECAY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_WEIGHT_0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_WEIGHT_1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_WEIGHT_2    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_WEIGHT_3    = 3'd6;

   // One statistics record per block
   typedef struct packed {
      logic [CNT_W-1:0] read_cnt;
      logic [CNT_W-1:0] write_cnt;
      logic [CNT_W-1:0] avg_len;
      logic [CNT_W-1:0] avg_rem;
      logic [RND_W-1:0] rnd;
   } stat_type;

   // Record write-back operations
   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZERO,
      WR_RAND,
      WR_FOLD,
      WR_ACCESS,
      WR_DEGRADE
   } wr_op_type;

   // Controller to datapath
   typedef struct packed {
      logic      capture;
      logic      mem_rd;
      logic      addr_idx;
      wr_op_type wr_op;
      logic      idx_ld_first;
      logic      idx_inc;
      logic      mul_en;
      logic      mul_score;
      logic      div_start;
      logic      div_score;
      logic      run_upd;
      logic      rsp_load;
      logic      rsp_direct;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              anchor_none;
      logic              blk_ok;
      logic              seq;
      logic              close_ok;
      logic              random;
      logic              idx_last;
      logic              idx_end;
      logic              div_done;
      logic              rsp_busy;
   } status_type;

endpackage

>>> hw/rtl/bht_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module bht_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bht_pkg::DVD_W-1:0]    dividend,
   input  logic [bht_pkg::DVS_W-1:0]    divisor,
   output logic                         busy,
   output logic                         done,
   output logic [bht_pkg::DVD_W-1:0]    quotient,
   output logic [bht_pkg::DVS_W-1:0]    remainder
);

   logic [bht_pkg::DVD_W-1:0]     quot_ff;
   logic [bht_pkg::DVS_W-1:0]     rem_ff;
   logic [bht_pkg::DVS_W-1:0]     dvs_ff;
   logic [bht_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [bht_pkg::DVS_W:0]       trial;
   logic [bht_pkg::DVS_W:0]       diff;
   logic                          ge;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, quot_ff[bht_pkg::DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= bht_pkg::DIV_CNT_W'(bht_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == bht_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[bht_pkg::DVS_W-1:0] : trial[bht_pkg::DVS_W-1:0];
         quot_ff <= {quot_ff[bht_pkg::DVD_W-2:0], ge};
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/bht_datapath.sv
// Datapath: statistics memory, run tracker, configuration, multiplier, divider, result register.
module bht_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  bht_pkg::cmd_type                 cmd,
   output bht_pkg::status_type              status,
   input  logic [bht_pkg::MODE_W-1:0]       req_mode,
   input  logic [bht_pkg::BLK_W-1:0]        req_block,
   input  logic [bht_pkg::SECTOR_W-1:0]     req_start_sector,
   input  logic [bht_pkg::END_W-1:0]        req_end_sector,
   input  logic                             req_is_write,
   input  logic [bht_pkg::TEMP_W-1:0]       req_temperature,
   input  logic [bht_pkg::ANCHOR_W-1:0]     req_anchor,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bht_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bht_pkg::SCORE_W-1:0]      rsp_score
);

   // Configuration
   logic [bht_pkg::THR_W-1:0]    thr_ff;
   logic [bht_pkg::LIMIT_W-1:0]  max_count_ff;
   logic [bht_pkg::LIMIT_W-1:0]  max_decay_ff;
   logic [bht_pkg::WEIGHT_W-1:0] weight_ff [bht_pkg::WEIGHT_SLOTS];

   // Captured transaction
   logic [bht_pkg::MODE_W-1:0]   mode_ff;
   logic [bht_pkg::BLK_W-1:0]    blk_ff;
   logic [bht_pkg::SECTOR_W-1:0] start_ff;
   logic [bht_pkg::END_W-1:0]    end_ff;
   logic                         is_write_ff;
   logic [bht_pkg::TEMP_W-1:0]   temp_ff;
   logic [bht_pkg::ANCHOR_W-1:0] anchor_ff;

   // Run tracker and walk index
   logic [bht_pkg::SECTOR_W-1:0] last_end_ff;
   logic [bht_pkg::BLK_W-1:0]    run_first_ff;
   logic [bht_pkg::BLK_W-1:0]    run_last_ff;
   logic [bht_pkg::BLK_W-1:0]    idx_ff;

   // Memory and arithmetic
   bht_pkg::stat_type            stat_mem_ff [bht_pkg::NUM_BLOCKS];
   bht_pkg::stat_type            rdata_ff;
   bht_pkg::stat_type            wdata;
   logic [bht_pkg::BLK_W-1:0]    addr;
   logic [bht_pkg::PROD_W-1:0]   prod_ff;
   logic                         rsp_valid_ff;
   logic [bht_pkg::SCORE_W-1:0]  rsp_score_ff;

   logic [bht_pkg::BLK_W-1:0]    len;
   logic [bht_pkg::FREQ_W-1:0]   freq;
   logic [bht_pkg::FREQ_W-1:0]   fold_x;
   logic [bht_pkg::CNT_W-1:0]    mul_b;
   logic [bht_pkg::DVD_W-1:0]    div_dvd;
   logic [bht_pkg::DVS_W-1:0]    div_dvs;
   logic [bht_pkg::DVD_W-1:0]    div_quot;
   logic [bht_pkg::DVS_W-1:0]    div_rem;
   logic                         div_busy;
   logic                         div_done;
   logic [bht_pkg::END_W-1:0]    end_m1;
   logic [bht_pkg::WEIGHT_W-1:0] weight;
   logic [bht_pkg::DVD_W-1:0]    score_adj;
   logic [bht_pkg::SCORE_W-1:0]  score_div;
   logic [bht_pkg::SCORE_W-1:0]  score_direct;

   function automatic logic [bht_pkg::CNT_W-1:0] sat_add(
      input logic [bht_pkg::CNT_W-1:0]    c,
      input logic [bht_pkg::WEIGHT_W-1:0] w
   );
      logic [bht_pkg::CNT_W:0] s;
      s = {1'b0, c} + {{(bht_pkg::CNT_W + 1 - bht_pkg::WEIGHT_W){1'b0}}, w};
      return s[bht_pkg::CNT_W] ? '1 : s[bht_pkg::CNT_W-1:0];
   endfunction

   function automatic logic [bht_pkg::CNT_W-1:0] decay(
      input logic [bht_pkg::CNT_W-1:0]   c,
      input logic [bht_pkg::LIMIT_W-1:0] lim,
      input logic [bht_pkg::LIMIT_W-1:0] dec
   );
      logic [bht_pkg::CNT_W-1:0] r;
      r = c;
      if (c > {1'b0, lim})
         r = (c > {1'b0, dec}) ? c - {1'b0, dec} : '0;
      return r;
   endfunction

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= bht_pkg::THR_W'(bht_pkg::RESET_RAND_THRESHOLD);
         max_count_ff <= bht_pkg::DEFAULT_MAX_COUNT;
         max_decay_ff <= bht_pkg::DEFAULT_MAX_DECAY;
         for (int i = 0; i < bht_pkg::WEIGHT_SLOTS; i++)
            weight_ff[i] <= bht_pkg::RESET_FREQ_WEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            bht_pkg::CSR_RANDOM_THRESHOLD: thr_ff       <= csr_wdata[bht_pkg::THR_W-1:0];
            bht_pkg::CSR_MAX_STAT_COUNT:   max_count_ff <= csr_wdata[bht_pkg::LIMIT_W-1:0];
            bht_pkg::CSR_MAX_STAT_DECAY:   max_decay_ff <= csr_wdata[bht_pkg::LIMIT_W-1:0];
            bht_pkg::CSR_FREQ_WEIGHT_0:    weight_ff[0] <= csr_wdata[bht_pkg::WEIGHT_W-1:0];
            bht_pkg::CSR_FREQ_WEIGHT_1:    weight_ff[1] <= csr_wdata[bht_pkg::WEIGHT_W-1:0];
            bht_pkg::CSR_FREQ_WEIGHT_2:    weight_ff[2] <= csr_wdata[bht_pkg::WEIGHT_W-1:0];
            bht_pkg::CSR_FREQ_WEIGHT_3:    weight_ff[3] <= csr_wdata[bht_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         blk_ff      <= req_block;
         start_ff    <= req_start_sector;
         end_ff      <= req_end_sector;
         is_write_ff <= req_is_write;
         temp_ff     <= req_temperature;
         anchor_ff   <= req_anchor;
      end
   end

   // Run tracker and walk index
   assign end_m1 = end_ff - bht_pkg::END_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_end_ff  <= '0;
         run_first_ff <= '0;
         run_last_ff  <= '0;
         idx_ff       <= '0;
      end else begin
         if (cmd.run_upd) begin
            if (!status.seq)
               run_first_ff <= blk_ff;
            run_last_ff <= blk_ff;
            last_end_ff <= end_m1[bht_pkg::SECTOR_W-1:0];
         end
         if (cmd.idx_ld_first)
            idx_ff <= run_first_ff;
         else if (cmd.idx_inc)
            idx_ff <= idx_ff + 1'b1;
      end
   end

   // Statistics memory, registered read
   assign addr = cmd.addr_idx ? idx_ff : blk_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_op != bht_pkg::WR_NONE)
         stat_mem_ff[addr] <= wdata;
      if (cmd.mem_rd)
         rdata_ff <= stat_mem_ff[addr];
   end

   // Shared arithmetic operands
   always_comb begin
      len    = run_last_ff - run_first_ff;
      freq   = {1'b0, rdata_ff.read_cnt} + {1'b0, rdata_ff.write_cnt};
      fold_x = {1'b0, rdata_ff.avg_rem}
             + {{(bht_pkg::FREQ_W - bht_pkg::BLK_W){1'b0}}, len};
      mul_b  = cmd.mul_score ? ({1'b0, rdata_ff.rnd} + bht_pkg::CNT_W'(1))
                             : rdata_ff.avg_len;
      if (cmd.div_score) begin
         div_dvd = {1'b0, prod_ff};
         div_dvs = {1'b0, {1'b0, rdata_ff.avg_len} + bht_pkg::FREQ_W'(1)};
      end else begin
         div_dvd = {1'b0, prod_ff}
                 + {{(bht_pkg::DVD_W - bht_pkg::FREQ_W){1'b0}}, fold_x};
         div_dvs = {1'b0, freq} + bht_pkg::DVS_W'(1);
      end
   end

   // 33x32 multiplier, registered
   always_ff @(posedge clock) begin
      if (cmd.mul_en)
         prod_ff <= {{(bht_pkg::PROD_W - bht_pkg::FREQ_W){1'b0}}, freq}
                  * {{(bht_pkg::PROD_W - bht_pkg::CNT_W){1'b0}}, mul_b};
   end

   bht_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Record update
   assign weight = ({1'b0, temp_ff} < (bht_pkg::TEMP_W + 1)'(bht_pkg::NUM_TEMPERATURES))
                 ? weight_ff[temp_ff] : '0;

   always_comb begin
      wdata = rdata_ff;
      case (cmd.wr_op)
         bht_pkg::WR_ZERO: wdata = '0;
         bht_pkg::WR_RAND:
            if (rdata_ff.rnd != bht_pkg::INT_MAX)
               wdata.rnd = rdata_ff.rnd + 1'b1;
         bht_pkg::WR_FOLD: begin
            wdata.avg_len = (|div_quot[bht_pkg::DVD_W-1:bht_pkg::CNT_W])
                          ? '1 : div_quot[bht_pkg::CNT_W-1:0];
            wdata.avg_rem = (|div_rem[bht_pkg::DVS_W-1:bht_pkg::CNT_W])
                          ? '1 : div_rem[bht_pkg::CNT_W-1:0];
         end
         bht_pkg::WR_ACCESS: begin
            wdata.read_cnt  = decay(sat_add(rdata_ff.read_cnt, is_write_ff ? '0 : weight),
                                    max_count_ff, max_decay_ff);
            wdata.write_cnt = decay(sat_add(rdata_ff.write_cnt, is_write_ff ? weight : '0),
                                    max_count_ff, max_decay_ff);
         end
         bht_pkg::WR_DEGRADE: begin
            wdata.read_cnt  = rdata_ff.read_cnt >> bht_pkg::HALVE_SHIFT;
            wdata.write_cnt = rdata_ff.write_cnt >> bht_pkg::HALVE_SHIFT;
            wdata.rnd       = rdata_ff.rnd >> bht_pkg::HALVE_SHIFT;
         end
         default: ;
      endcase
   end

   // Score formation
   always_comb begin
      score_adj = (div_quot == '0 && freq != '0) ? bht_pkg::DVD_W'(1) : div_quot;
      score_div = (|score_adj[bht_pkg::DVD_W-1:bht_pkg::SCORE_W])
                ? '1 : score_adj[bht_pkg::SCORE_W-1:0];
      score_direct = (anchor_ff == bht_pkg::ANCHOR_FORCE_HOT)
                   ? {{(bht_pkg::SCORE_W - bht_pkg::LIMIT_W){1'b0}}, max_count_ff} : '0;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load)
         rsp_score_ff <= cmd.rsp_direct ? score_direct : score_div;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;

   // Status to controller
   always_comb begin
      status.mode        = mode_ff;
      status.anchor_none = anchor_ff == bht_pkg::ANCHOR_NONE;
      status.blk_ok      = {1'b0, blk_ff} < (bht_pkg::BLK_W + 1)'(bht_pkg::NUM_BLOCKS);
      status.seq         = {1'b0, start_ff} == ({1'b0, last_end_ff} + bht_pkg::END_W'(1));
      status.close_ok    = run_last_ff >= run_first_ff;
      status.random      = len < thr_ff;
      status.idx_last    = (idx_ff == run_last_ff)
                        || (({1'b0, idx_ff} + 1'b1) >= (bht_pkg::BLK_W + 1)'(bht_pkg::NUM_BLOCKS));
      status.idx_end     = idx_ff == bht_pkg::BLK_W'(bht_pkg::NUM_BLOCKS - 1);
      status.div_done    = div_done;
      status.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // A new result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result loaded over a pending result");

   // The divider is only started when idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // No memory write while a division that feeds it is running
   assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (cmd.wr_op == bht_pkg::WR_NONE && !cmd.mul_en))
      else $error("datapath disturbed during division");

endmodule

>>> hw/rtl/bht_ctrl.sv
// Controller state machine sequencing run walks, updates and score queries.
module bht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bht_pkg::status_type status,
   output bht_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_DATA,
      ST_WALK_DST,
      ST_WALK_DIV,
      ST_WALK_WR,
      ST_RUN,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_CLR_WR,
      ST_DEG_RD,
      ST_DEG_WR,
      ST_SC_RD,
      ST_SC_MUL,
      ST_SC_DST,
      ST_SC_DIV,
      ST_RES_DIRECT,
      ST_RES_DIV
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_op = bht_pkg::WR_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.addr_idx = 1'b1;
            cmd.wr_op    = bht_pkg::WR_ZERO;
            if (status.idx_end) state_in = ST_IDLE;
            else cmd.idx_inc = 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.mode)
               bht_pkg::MODE_ACCESS: begin
                  if (!status.seq && status.close_ok) begin
                     cmd.idx_ld_first = 1'b1;
                     state_in         = ST_WALK_RD;
                  end else begin
                     state_in = ST_RUN;
                  end
               end
               bht_pkg::MODE_CLEAR:   state_in = status.blk_ok ? ST_CLR_WR : ST_IDLE;
               bht_pkg::MODE_DEGRADE: state_in = status.blk_ok ? ST_DEG_RD : ST_IDLE;
               default:
                  state_in = (status.anchor_none && status.blk_ok) ? ST_SC_RD : ST_RES_DIRECT;
            endcase
         end
         ST_WALK_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_idx = 1'b1;
            state_in     = ST_WALK_DATA;
         end
         ST_WALK_DATA: begin
            if (status.random) begin
               cmd.addr_idx = 1'b1;
               cmd.wr_op    = bht_pkg::WR_RAND;
               if (status.idx_last) state_in = ST_RUN;
               else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_WALK_RD;
               end
            end else begin
               cmd.mul_en = 1'b1;
               state_in   = ST_WALK_DST;
            end
         end
         ST_WALK_DST: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WALK_DIV;
         end
         ST_WALK_DIV: if (status.div_done) state_in = ST_WALK_WR;
         ST_WALK_WR: begin
            cmd.addr_idx = 1'b1;
            cmd.wr_op    = bht_pkg::WR_FOLD;
            if (status.idx_last) state_in = ST_RUN;
            else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_WALK_RD;
            end
         end
         ST_RUN: begin
            cmd.run_upd = 1'b1;
            state_in    = status.blk_ok ? ST_ACC_RD : ST_IDLE;
         end
         ST_ACC_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            cmd.wr_op = bht_pkg::WR_ACCESS;
            state_in  = ST_IDLE;
         end
         ST_CLR_WR: begin
            cmd.wr_op = bht_pkg::WR_ZERO;
            state_in  = ST_IDLE;
         end
         ST_DEG_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DEG_WR;
         end
         ST_DEG_WR: begin
            cmd.wr_op = bht_pkg::WR_DEGRADE;
            state_in  = ST_IDLE;
         end
         ST_SC_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_score = 1'b1;
            state_in      = ST_SC_DST;
         end
         ST_SC_DST: begin
            cmd.div_start = 1'b1;
            cmd.div_score = 1'b1;
            state_in      = ST_SC_DIV;
         end
         ST_SC_DIV: if (status.div_done) state_in = ST_RES_DIV;
         ST_RES_DIRECT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_direct = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_RES_DIV: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hw/rtl/block_hotness_tracker.sv
// Top level of the block hotness tracker.
// After reset the block sweeps its 4096-entry statistics memory to zero, one
// entry per cycle, with req_ready low; csr writes are taken at any time.
// Transactions are handled one at a time. An access that closes a run first
// walks every block of that run: when the run counts as random, it bumps each
// block's randomness count; otherwise the bit-serial divider folds the run
// length into each block average. A computed score also goes through the
// divider, while an anchored score is loaded directly. A finished score waits
// in an output register, so the next transaction can start before it is taken;
// a second score stalls in the block until the first one has been taken.
module block_hotness_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bht_pkg::MODE_W-1:0]       req_mode,
   input  logic [bht_pkg::BLK_W-1:0]        req_block,
   input  logic [bht_pkg::SECTOR_W-1:0]     req_start_sector,
   input  logic [bht_pkg::END_W-1:0]        req_end_sector,
   input  logic                             req_is_write,
   input  logic [bht_pkg::TEMP_W-1:0]       req_temperature,
   input  logic [bht_pkg::ANCHOR_W-1:0]     req_anchor,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bht_pkg::SCORE_W-1:0]      rsp_score,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bht_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bht_pkg::cmd_type    cmd;
   bht_pkg::status_type status;

   bht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bht_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_block        (req_block),
      .req_start_sector (req_start_sector),
      .req_end_sector   (req_end_sector),
      .req_is_write     (req_is_write),
      .req_temperature  (req_temperature),
      .req_anchor       (req_anchor),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_score        (rsp_score)
   );

endmodule

>>> tb/bht_checker.sv
// Scoreboard for the block hotness tracker: mirrors its statistics and checks every score.
`timescale 1ns / 1ps

module bht_checker
   import bht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [BLK_W-1:0]      req_block,
   input  logic [SECTOR_W-1:0]   req_start_sector,
   input  logic [END_W-1:0]      req_end_sector,
   input  logic                  req_is_write,
   input  logic [TEMP_W-1:0]     req_temperature,
   input  logic [ANCHOR_W-1:0]   req_anchor,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SCORE_W-1:0]    rsp_score,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending
);

   localparam logic [127:0] CNT_SAT   = 128'hFFFF_FFFF;
   localparam logic [127:0] SCORE_SAT = 128'h7FFF_FFFF_FFFF_FFFF;

   // Mirrored configuration
   logic [THR_W-1:0]    thr;
   logic [LIMIT_W-1:0]  cnt_limit;
   logic [LIMIT_W-1:0]  cnt_decay;
   logic [WEIGHT_W-1:0] weight [WEIGHT_SLOTS];

   // Mirrored per-block statistics and run tracker
   logic [CNT_W-1:0]    rd_cnt  [NUM_BLOCKS];
   logic [CNT_W-1:0]    wr_cnt  [NUM_BLOCKS];
   logic [CNT_W-1:0]    avg_len [NUM_BLOCKS];
   logic [CNT_W-1:0]    avg_rem [NUM_BLOCKS];
   logic [RND_W-1:0]    rnd     [NUM_BLOCKS];
   logic [SECTOR_W-1:0] last_end;
   logic [BLK_W-1:0]    run_first;
   logic [BLK_W-1:0]    run_last;

   logic [SCORE_W-1:0]  score_q [$];

   function automatic logic [CNT_W-1:0] sat_cnt(logic [127:0] v);
      return (v > CNT_SAT) ? CNT_SAT[CNT_W-1:0] : v[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] decay_cnt(logic [CNT_W-1:0] c);
      if (c > {1'b0, cnt_limit})
         c = (c > {1'b0, cnt_decay}) ? c - {1'b0, cnt_decay} : '0;
      return c;
   endfunction

   // Fold a finished run length into one block's running average
   task automatic fold_len(int b, logic [BLK_W-1:0] len);
      logic [127:0] f, t, d;
      f = 128'(rd_cnt[b]) + 128'(wr_cnt[b]);
      t = f * 128'(avg_len[b]) + 128'(avg_rem[b]) + 128'(len);
      d = f + 128'd1;
      avg_len[b] = sat_cnt(t / d);
      avg_rem[b] = sat_cnt(t % d);
   endtask

   // Walk the closed run: short runs bump randomness, long ones fold length
   task automatic close_run();
      logic [BLK_W-1:0] len;
      if (run_last < run_first) return;
      len = run_last - run_first;
      for (int k = run_first; k <= run_last; k++) begin
         if (len < thr) begin
            if (rnd[k] != INT_MAX) rnd[k] = rnd[k] + 1'b1;
         end else begin
            fold_len(k, len);
         end
      end
   endtask

   function automatic logic [SCORE_W-1:0] hot_score(int b, logic [ANCHOR_W-1:0] anc);
      logic [127:0] f, s;
      if (anc != ANCHOR_NONE) return (anc == ANCHOR_FORCE_HOT) ? SCORE_W'(cnt_limit) : '0;
      f = 128'(rd_cnt[b]) + 128'(wr_cnt[b]);
      s = f * (128'(rnd[b]) + 128'd1) / (128'(avg_len[b]) + 128'd1);
      if (s == 0 && f != 0) s = 128'd1;
      return (s > SCORE_SAT) ? SCORE_SAT[SCORE_W-1:0] : s[SCORE_W-1:0];
   endfunction

   task automatic apply_req();
      int b;
      logic [WEIGHT_W-1:0] w;
      b = req_block;
      case (req_mode)
         MODE_ACCESS: begin
            if ({1'b0, req_start_sector} != END_W'(last_end) + END_W'(1)) begin
               close_run();
               run_first = req_block;
            end
            run_last = req_block;
            last_end = SECTOR_W'(req_end_sector - END_W'(1));
            w = (req_temperature < NUM_TEMPERATURES) ? weight[req_temperature] : '0;
            if (req_is_write) wr_cnt[b] = sat_cnt(128'(wr_cnt[b]) + 128'(w));
            else              rd_cnt[b] = sat_cnt(128'(rd_cnt[b]) + 128'(w));
            rd_cnt[b] = decay_cnt(rd_cnt[b]);
            wr_cnt[b] = decay_cnt(wr_cnt[b]);
         end
         MODE_CLEAR: begin
            rd_cnt[b] = '0; wr_cnt[b] = '0; avg_len[b] = '0; avg_rem[b] = '0; rnd[b] = '0;
         end
         MODE_DEGRADE: begin
            rd_cnt[b] = rd_cnt[b] >> HALVE_SHIFT;
            wr_cnt[b] = wr_cnt[b] >> HALVE_SHIFT;
            rnd[b]    = rnd[b] >> HALVE_SHIFT;
         end
         default: score_q.push_back(hot_score(b, req_anchor));
      endcase
   endtask

   task automatic report(string what, logic [SCORE_W-1:0] got, logic [SCORE_W-1:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         thr       = THR_W'(RESET_RAND_THRESHOLD);
         cnt_limit = DEFAULT_MAX_COUNT;
         cnt_decay = DEFAULT_MAX_DECAY;
         foreach (weight[i]) weight[i] = RESET_FREQ_WEIGHT;
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            rd_cnt[i] = '0; wr_cnt[i] = '0; avg_len[i] = '0; avg_rem[i] = '0; rnd[i] = '0;
         end
         last_end  = '0;
         run_first = '0;
         run_last  = '0;
         score_q.delete();
      end else begin
         // result transaction against the oldest expected score
         if (rsp_valid && rsp_ready) begin
            if (score_q.size() == 0) report("unexpected score", rsp_score, '0);
            else begin
               logic [SCORE_W-1:0] want;
               want = score_q.pop_front();
               if (rsp_score !== want) report("score", rsp_score, want);
            end
         end
         // register write transaction
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RANDOM_THRESHOLD: thr       = csr_wdata[THR_W-1:0];
               CSR_MAX_STAT_COUNT:   cnt_limit = csr_wdata[LIMIT_W-1:0];
               CSR_MAX_STAT_DECAY:   cnt_decay = csr_wdata[LIMIT_W-1:0];
               CSR_FREQ_WEIGHT_0:    weight[0] = csr_wdata[WEIGHT_W-1:0];
               CSR_FREQ_WEIGHT_1:    weight[1] = csr_wdata[WEIGHT_W-1:0];
               CSR_FREQ_WEIGHT_2:    weight[2] = csr_wdata[WEIGHT_W-1:0];
               CSR_FREQ_WEIGHT_3:    weight[3] = csr_wdata[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         // request transaction
         if (req_valid && req_ready) apply_req();
      end
      pending = score_q.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the block hotness tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import bht_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode;
   logic [BLK_W-1:0]      req_block;
   logic [SECTOR_W-1:0]   req_start_sector;
   logic [END_W-1:0]      req_end_sector;
   logic                  req_is_write;
   logic [TEMP_W-1:0]     req_temperature;
   logic [ANCHOR_W-1:0]   req_anchor;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SCORE_W-1:0]    rsp_score;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    errors;
   int                    pending;

   // Stimulus-side run tracking, so sequential runs stay short
   logic [END_W-1:0]      next_start;
   int                    run_base;
   bit                    no_gaps;
   bit                    long_hold;

   block_hotness_tracker u_dut (.*);

   bht_checker u_checker (.*);

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // Watchdog
   initial begin
      #50ms;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SECTOR_W-1:0] rand_sector();
      return SECTOR_W'({$urandom, $urandom});
   endfunction

   // Block near the current run start: mostly ahead, sometimes behind, rarely far
   function automatic logic [BLK_W-1:0] near_block();
      int r, b;
      r = $urandom_range(0, 999);
      if (r < 5)        b = run_base + $urandom_range(0, 300);
      else if (r < 105) b = run_base - $urandom_range(1, 8);
      else              b = run_base + $urandom_range(0, 8);
      if (b < 0) b = 0;
      if (b >= NUM_BLOCKS) b = NUM_BLOCKS - 1;
      return BLK_W'(b);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         g = pick_gap();
         if (long_hold) begin
            g = 3000;
            long_hold = 1'b0;
         end
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(int unsigned t, int unsigned c, int unsigned d,
                             int unsigned w0, int unsigned w1, int unsigned w2,
                             int unsigned w3);
      csr_write(CSR_RANDOM_THRESHOLD, CSR_DATA_W'(t));
      csr_write(CSR_MAX_STAT_COUNT,   CSR_DATA_W'(c));
      csr_write(CSR_MAX_STAT_DECAY,   CSR_DATA_W'(d));
      csr_write(CSR_FREQ_WEIGHT_0,    CSR_DATA_W'(w0));
      csr_write(CSR_FREQ_WEIGHT_1,    CSR_DATA_W'(w1));
      csr_write(CSR_FREQ_WEIGHT_2,    CSR_DATA_W'(w2));
      csr_write(CSR_FREQ_WEIGHT_3,    CSR_DATA_W'(w3));
   endtask

   // One request transaction, called at a falling edge
   task automatic send(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk,
                       logic [SECTOR_W-1:0] start, logic [END_W-1:0] stop,
                       logic wr, logic [TEMP_W-1:0] temp, logic [ANCHOR_W-1:0] anc);
      int g;
      req_mode         <= mode;
      req_block        <= blk;
      req_start_sector <= start;
      req_end_sector   <= stop;
      req_is_write     <= wr;
      req_temperature  <= temp;
      req_anchor       <= anc;
      req_valid        <= 1'b1;
      if (mode == MODE_ACCESS) begin
         if ({1'b0, start} != next_start) run_base = blk;
         next_start = END_W'(SECTOR_W'(stop - END_W'(1))) + END_W'(1);
      end
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic seq_access();
      logic [SECTOR_W-1:0] s;
      s = next_start[SECTOR_W] ? rand_sector() : next_start[SECTOR_W-1:0];
      send(MODE_ACCESS, near_block(), s, END_W'(s) + END_W'($urandom_range(1, 64)),
           1'($urandom), TEMP_W'($urandom), '0);
   endtask

   task automatic rand_item();
      int r;
      logic [ANCHOR_W-1:0] anc;
      r = $urandom_range(0, 99);
      if (r < 45) seq_access();
      else if (r < 60)
         send(MODE_ACCESS, BLK_W'($urandom), rand_sector(), END_W'({$urandom, $urandom}),
              1'($urandom), TEMP_W'($urandom), ANCHOR_W'($urandom));
      else if (r < 68) send(MODE_CLEAR, near_block(), rand_sector(), '1, 1'b0, '0, '0);
      else if (r < 76) send(MODE_DEGRADE, near_block(), '0, '0, 1'b1, '1, '1);
      else begin
         anc = ($urandom_range(0, 4) == 0) ? ANCHOR_W'($urandom) : ANCHOR_NONE;
         send(MODE_SCORE, near_block(), rand_sector(), END_W'({$urandom, $urandom}),
              1'($urandom), TEMP_W'($urandom), anc);
      end
   endtask

   // Close a phase: the last score drains everything queued before it
   task automatic drain();
      send(MODE_SCORE, BLK_W'(run_base), '0, END_W'(1), 1'b0, '0, ANCHOR_NONE);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (100) @(negedge clock);
   endtask

   task automatic rand_phase(int n);
      for (int i = 0; i < n; i++) rand_item();
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = MODE_ACCESS;
      req_block  = '0;
      req_start_sector = '0;
      req_end_sector   = '0;
      req_is_write     = 1'b0;
      req_temperature  = '0;
      req_anchor       = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_RANDOM_THRESHOLD;
      csr_wdata  = '0;
      next_start = END_W'(1);
      run_base   = 0;
      no_gaps    = 1'b0;
      long_hold  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, every mode and anchor, backward and folded runs
      send(MODE_SCORE,   12'd0,    '0, END_W'(1), 1'b0, 2'd0, ANCHOR_NONE);
      send(MODE_ACCESS,  12'd0,    48'd1, 49'd5, 1'b0, 2'd0, '0);
      send(MODE_ACCESS,  12'd3,    48'd5, 49'd9, 1'b1, 2'd1, '0);
      send(MODE_ACCESS,  12'd4095, '1, 49'h1_0000_0000_0000, 1'b1, 2'd2, '0);
      send(MODE_ACCESS,  12'd4094, '0, '0, 1'b0, 2'd3, '0);
      send(MODE_ACCESS,  12'd10,   48'd7, 49'd20, 1'b0, 2'd1, '0);
      send(MODE_ACCESS,  12'd2,    48'd20, 49'd30, 1'b1, 2'd2, '0);
      send(MODE_ACCESS,  12'd20,   48'd100, 49'd200, 1'b0, 2'd3, '0);
      send(MODE_ACCESS,  12'd26,   48'd200, 49'd300, 1'b1, 2'd0, '0);
      send(MODE_ACCESS,  12'd27,   48'd300, 49'd400, 1'b0, 2'd1, '0);
      send(MODE_ACCESS,  12'd5,    48'd9999, 49'd10000, 1'b1, 2'd3, '0);
      send(MODE_SCORE,   12'd20,   '0, '0, 1'b0, '0, ANCHOR_NONE);
      send(MODE_SCORE,   12'd26,   '0, '0, 1'b0, '0, ANCHOR_NONE);
      send(MODE_SCORE,   12'd4095, '0, '0, 1'b0, '0, ANCHOR_NONE);
      send(MODE_SCORE,   12'd20,   '0, '0, 1'b0, '0, ANCHOR_FORCE_HOT);
      send(MODE_SCORE,   12'd20,   '0, '0, 1'b0, '0, ANCHOR_COLD);
      send(MODE_SCORE,   12'd20,   '0, '0, 1'b0, '0, ANCHOR_W'(3));
      send(MODE_DEGRADE, 12'd20,   '0, '0, 1'b0, '0, '0);
      send(MODE_SCORE,   12'd20,   '0, '0, 1'b0, '0, ANCHOR_NONE);
      send(MODE_CLEAR,   12'd27,   '0, '0, 1'b0, '0, '0);
      send(MODE_SCORE,   12'd27,   '0, '0, 1'b0, '0, ANCHOR_NONE);
      drain();

      // Random phases across register settings
      rand_phase(300);
      set_config(0, 32'h7FFF_FFFF, 0, 65535, 1, 0, 7);
      rand_phase(300);
      set_config(4095, 0, 32'h7FFF_FFFF, $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
      rand_phase(250);
      set_config(3, 100, 30, 1, 2, 3, 4);
      for (int i = 0; i < 300; i++) begin
         if (i == 40) long_hold = 1'b1;
         rand_item();
      end
      drain();
      set_config($urandom_range(0, 4095), $urandom_range(0, 5000),
                 $urandom_range(0, 5000), $urandom, $urandom, $urandom, $urandom);
      no_gaps = 1'b1;
      rand_phase(250);
      no_gaps = 1'b0;
      set_config(2, 32'h7FFF_FFFF, 1, 65535, 65535, 65535, 65535);
      rand_phase(420);

      if (errors == 0 && pending == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bht_pkg.sv
hw/rtl/bht_div.sv
hw/rtl/bht_datapath.sv
hw/rtl/bht_ctrl.sv
hw/rtl/block_hotness_tracker.sv
tb/bht_checker.sv
tb/tb_top.sv
